FILE: hdl/gfbp_pkg.sv
// shared constants and the decoded request type of the gap-filling bit packer
// no dependencies

package gfbp_pkg;

    localparam int PENDING_DEPTH_DEF = 32;
    localparam int SLOT_DEPTH_DEF    = 16;
    localparam int SMALL_WIDTH_LIMIT = 4;
    localparam int BITS_PER_BYTE     = 8;
    localparam int MAX_RESULTS       = 32;
    localparam int MAX_WIDTH         = 32;

    // request after masking, clamping and prefix selection
    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  width;
        logic [2:0]  nbytes;
        logic [1:0]  pfx_bits;
        logic [1:0]  pfx_len;
        logic        slot_need;
        logic [2:0]  slot_start;
    } item_t;

endpackage

FILE: hdl/gfbp_decode.sv
// request decoder: clamps the width, masks the value, sizes the byte run
// and picks the byte-count prefix; depends on gfbp_pkg

module gfbp_decode
(
    input  logic [31:0]     value,
    input  logic [5:0]      width_bits,
    output gfbp_pkg::item_t item
);

    logic [5:0]  w;
    logic [32:0] mask33;
    logic [31:0] vm;
    logic [2:0]  nb;

    always_comb
    begin
        w      = (width_bits > 6'(gfbp_pkg::MAX_WIDTH)) ? 6'(gfbp_pkg::MAX_WIDTH) : width_bits;
        mask33 = (33'd1 << w) - 33'd1;
        vm     = value & mask33[31:0];
        if (vm[31:24] != 8'd0)
            nb = 3'd4;
        else if (vm[23:16] != 8'd0)
            nb = 3'd3;
        else if (vm[15:8] != 8'd0)
            nb = 3'd2;
        else
            nb = 3'd1;

        item.value      = vm;
        item.width      = w;
        item.nbytes     = nb;
        item.slot_need  = ({nb, 3'b000} > w);
        item.slot_start = w[2:0];

        // byte-count prefix, middle width range favors two bytes
        if (w <= 6'd16)
        begin
            item.pfx_bits = 2'(nb - 3'd1);
            item.pfx_len  = 2'd1;
        end
        else if (w <= 6'd24)
        begin
            if (nb == 3'd2)
            begin
                item.pfx_bits = 2'd1;
                item.pfx_len  = 2'd1;
            end
            else if (nb == 3'd1)
            begin
                item.pfx_bits = 2'd0;
                item.pfx_len  = 2'd2;
            end
            else
            begin
                item.pfx_bits = 2'd2;
                item.pfx_len  = 2'd2;
            end
        end
        else
        begin
            item.pfx_bits = 2'(nb - 3'd1);
            item.pfx_len  = 2'd2;
        end
    end

endmodule

FILE: hdl/gap_filling_bit_packer.sv
// gap-filling bit packer top level: sequencer, pending byte memory, slot memory
// depends on gfbp_pkg and gfbp_decode
//
// operation: each request runs twice, a check pass then a write pass; each slot boundary
// crossed adds a slot memory read in each pass, each appended byte a pending memory write in
// the write pass, and each emitted byte one pending memory read and one output load, plus
// any output stall
// requests: one at a time, the next is taken only while the block is idle (in_stall low)
// reset clears byte count, slot count and the output register; the memories are not cleared

module gap_filling_bit_packer #(
    parameter int PENDING_DEPTH = gfbp_pkg::PENDING_DEPTH_DEF,
    parameter int SLOT_DEPTH    = gfbp_pkg::SLOT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] value,
    input  logic [5:0]  width_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        overflow,
    output logic        last
);

    localparam int AW  = $clog2(PENDING_DEPTH);
    localparam int CW  = $clog2(PENDING_DEPTH + 1);
    localparam int SAW = $clog2(SLOT_DEPTH);
    localparam int SCW = $clog2(SLOT_DEPTH + 1);
    localparam int ETW = $clog2(PENDING_DEPTH + gfbp_pkg::MAX_RESULTS + 8);
    localparam int SW  = AW + 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PUSH,
        S_FILL,
        S_SLOT,
        S_POST,
        S_APPEND,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_FINISH,
        S_REPORT
    } state_t;

    // circular add into the pending store
    function automatic logic [AW-1:0] padd(logic [AW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(PENDING_DEPTH))
            s = s - (CW+1)'(PENDING_DEPTH);
        return s[AW-1:0];
    endfunction

    // circular distance from head to a byte position
    function automatic logic [CW-1:0] pdist(logic [AW-1:0] pos, logic [AW-1:0] h);
        logic [CW:0] s;
        s = (CW+1)'(pos) + (CW+1)'(PENDING_DEPTH) - (CW+1)'(h);
        if (s >= (CW+1)'(PENDING_DEPTH))
            s = s - (CW+1)'(PENDING_DEPTH);
        return s[CW-1:0];
    endfunction

    // circular add into the slot queue
    function automatic logic [SAW-1:0] sadd(logic [SAW-1:0] a, logic [SCW-1:0] b);
        logic [SCW:0] s;
        s = (SCW+1)'(a) + (SCW+1)'(b);
        if (s >= (SCW+1)'(SLOT_DEPTH))
            s = s - (SCW+1)'(SLOT_DEPTH);
        return s[SAW-1:0];
    endfunction

    gfbp_pkg::item_t dec;
    gfbp_pkg::item_t item_reg;

    state_t         state_reg;
    state_t         ret_reg;
    logic           mode_reg;
    logic           dry_reg;
    logic           rej_reg;
    logic           fresh_reg;
    logic [ETW-1:0] ecnt_reg;
    logic [ETW-1:0] etot_reg;
    logic [CW-1:0]  rem_reg;
    logic [1:0]     idx_reg;
    logic [7:0]     pbits_reg;
    logic [3:0]     pn_reg;

    // committed state
    logic [AW-1:0]  h_reg;
    logic [CW-1:0]  c_reg;
    logic [SAW-1:0] sh_reg;
    logic [SCW-1:0] sc_reg;
    logic [2:0]     hb_reg;

    // working copy for the pass in progress
    logic [AW-1:0]  wh_reg;
    logic [CW-1:0]  wc_reg;
    logic [SAW-1:0] wsh_reg;
    logic [SCW-1:0] wsc_reg;
    logic [2:0]     whb_reg;

    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           byte_valid_reg;
    logic           overflow_reg;
    logic           last_reg;

    // memories
    logic [7:0]     pend_mem [PENDING_DEPTH];
    logic [7:0]     pend_q;
    logic           pend_we;
    logic [AW-1:0]  pend_waddr;
    logic [7:0]     pend_wdata;
    logic           pend_re;
    logic [SW-1:0]  slot_mem [SLOT_DEPTH];
    logic [SW-1:0]  slot_q;
    logic           slot_we;
    logic [SAW-1:0] slot_waddr;
    logic [SW-1:0]  slot_wdata;
    logic           slot_re;
    logic [SAW-1:0] slot_raddr;

    // slot fill datapath
    logic [3:0]     fill_room;
    logic [3:0]     fill_k;
    logic [8:0]     fill_mask;
    logic [15:0]    fill_shift;
    logic           fill_full;
    logic [7:0]     app_byte;
    logic           app_last;
    logic [CW-1:0]  app_wc;
    logic           small_item;
    logic           out_free;
    logic           out_load;

    gfbp_decode u_decode
    (
        .value      (value),
        .width_bits (width_bits),
        .item       (dec)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign overflow   = overflow_reg;
    assign last       = last_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = out_free && ((state_reg == S_EMIT_OUT) || (state_reg == S_REPORT));
    assign small_item = (item_reg.width <= 6'(gfbp_pkg::SMALL_WIDTH_LIMIT));

    always_comb
    begin
        fill_room  = 4'd8 - {1'b0, whb_reg};
        fill_k     = (fill_room > pn_reg) ? pn_reg : fill_room;
        fill_mask  = (9'd1 << fill_k) - 9'd1;
        fill_shift = 16'(pbits_reg & fill_mask[7:0]) << whb_reg;
        fill_full  = (({1'b0, whb_reg} + fill_k) == 4'd8);

        case (idx_reg)
            2'd0:    app_byte = item_reg.value[7:0];
            2'd1:    app_byte = item_reg.value[15:8];
            2'd2:    app_byte = item_reg.value[23:16];
            default: app_byte = item_reg.value[31:24];
        endcase
        app_last = dry_reg || (3'(idx_reg) == (item_reg.nbytes - 3'd1));
        app_wc   = dry_reg ? (wc_reg + CW'(item_reg.nbytes)) : (wc_reg + CW'(1));
    end

    // memory port controls
    always_comb
    begin
        pend_we    = 1'b0;
        pend_waddr = wh_reg;
        pend_wdata = (fresh_reg ? 8'd0 : pend_q) | fill_shift[7:0];
        pend_re    = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = sadd(wsh_reg, wsc_reg);
        slot_wdata = {padd(wh_reg, wc_reg), item_reg.slot_start};
        slot_re    = 1'b0;
        slot_raddr = sadd(wsh_reg, SCW'(1));
        if (!dry_reg)
        begin
            unique case (state_reg)
                S_PUSH:
                begin
                    pend_re = (pn_reg != 4'd0) && (wsc_reg != SCW'(0));
                end
                S_FILL:
                begin
                    pend_we = 1'b1;
                end
                S_APPEND:
                begin
                    pend_we    = 1'b1;
                    pend_waddr = padd(wh_reg, wc_reg);
                    pend_wdata = app_byte;
                    slot_we    = app_last && item_reg.slot_need && (wsc_reg != SCW'(0));
                end
                S_EMIT_RD:
                begin
                    pend_re = (rem_reg != CW'(0));
                end
                default:
                begin
                end
            endcase
        end
        if ((state_reg == S_FILL) && fill_full && (wsc_reg > SCW'(1)))
            slot_re = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[pend_waddr] <= pend_wdata;
        if (pend_re)
            pend_q <= pend_mem[wh_reg];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_q <= slot_mem[slot_raddr];
    end

    // sequencer: check pass (dry) proves the request fits, write pass commits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            item_reg       <= '0;
            mode_reg       <= 1'b0;
            dry_reg        <= 1'b0;
            rej_reg        <= 1'b0;
            fresh_reg      <= 1'b0;
            ecnt_reg       <= '0;
            etot_reg       <= '0;
            rem_reg        <= '0;
            idx_reg        <= '0;
            pbits_reg      <= '0;
            pn_reg         <= '0;
            h_reg          <= '0;
            c_reg          <= '0;
            sh_reg         <= '0;
            sc_reg         <= '0;
            hb_reg         <= '0;
            wh_reg         <= '0;
            wc_reg         <= '0;
            wsh_reg        <= '0;
            wsc_reg        <= '0;
            whb_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            overflow_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= dec;
                        mode_reg  <= mode;
                        dry_reg   <= 1'b1;
                        rej_reg   <= 1'b0;
                        state_reg <= S_START;
                    end
                end

                S_START:
                begin
                    wh_reg   <= h_reg;
                    wc_reg   <= c_reg;
                    wsh_reg  <= sh_reg;
                    wsc_reg  <= mode_reg ? '0 : sc_reg;
                    whb_reg  <= hb_reg;
                    ecnt_reg <= '0;
                    if (mode_reg)
                    begin
                        // finalize: drop every slot and flush the whole store
                        rem_reg   <= c_reg;
                        ret_reg   <= S_FINISH;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        if (small_item)
                        begin
                            pbits_reg <= item_reg.value[7:0];
                            pn_reg    <= item_reg.width[3:0];
                        end
                        else if (item_reg.width > 6'(gfbp_pkg::BITS_PER_BYTE))
                        begin
                            pbits_reg <= {6'd0, item_reg.pfx_bits};
                            pn_reg    <= {2'd0, item_reg.pfx_len};
                        end
                        else
                        begin
                            pbits_reg <= '0;
                            pn_reg    <= '0;
                        end
                        state_reg <= S_PUSH;
                    end
                end

                S_PUSH:
                begin
                    if (pn_reg == 4'd0)
                        state_reg <= S_POST;
                    else if (wsc_reg == SCW'(0))
                    begin
                        // open a fresh zero byte as the only slot
                        wc_reg    <= CW'(1);
                        wsc_reg   <= SCW'(1);
                        whb_reg   <= 3'd0;
                        fresh_reg <= 1'b1;
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        fresh_reg <= 1'b0;
                        state_reg <= S_FILL;
                    end
                end

                S_FILL:
                begin
                    pbits_reg <= pbits_reg >> fill_k;
                    pn_reg    <= pn_reg - fill_k;
                    if (fill_full)
                    begin
                        if (wsc_reg == SCW'(1))
                        begin
                            wsc_reg   <= '0;
                            rem_reg   <= wc_reg;
                            ret_reg   <= S_PUSH;
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            wsc_reg   <= wsc_reg - SCW'(1);
                            wsh_reg   <= sadd(wsh_reg, SCW'(1));
                            state_reg <= S_SLOT;
                        end
                    end
                    else
                    begin
                        whb_reg   <= 3'({1'b0, whb_reg} + fill_k);
                        state_reg <= S_PUSH;
                    end
                end

                S_SLOT:
                begin
                    // next slot becomes head; bytes ahead of it go out
                    whb_reg   <= slot_q[2:0];
                    rem_reg   <= pdist(slot_q[SW-1:3], wh_reg);
                    ret_reg   <= S_PUSH;
                    state_reg <= S_EMIT_RD;
                end

                S_POST:
                begin
                    if (small_item)
                        state_reg <= S_FINISH;
                    else if (((CW+1)'(wc_reg) + (CW+1)'(item_reg.nbytes)) >
                             (CW+1)'(PENDING_DEPTH))
                    begin
                        rej_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else if (item_reg.slot_need && (wsc_reg >= SCW'(SLOT_DEPTH)))
                    begin
                        rej_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_APPEND;
                    end
                end

                S_APPEND:
                begin
                    wc_reg  <= app_wc;
                    idx_reg <= idx_reg + 2'd1;
                    if (app_last)
                    begin
                        // unused top of the last byte becomes a slot
                        if (item_reg.slot_need)
                        begin
                            wsc_reg <= wsc_reg + SCW'(1);
                            if (wsc_reg == SCW'(0))
                                whb_reg <= item_reg.slot_start;
                        end
                        if (wsc_reg == SCW'(0))
                            rem_reg <= item_reg.slot_need ? (app_wc - CW'(1)) : app_wc;
                        else
                            rem_reg <= '0;
                        ret_reg   <= S_FINISH;
                        state_reg <= S_EMIT_RD;
                    end
                end

                S_EMIT_RD:
                begin
                    if (rem_reg == CW'(0))
                        state_reg <= ret_reg;
                    else if (dry_reg)
                    begin
                        ecnt_reg  <= ecnt_reg + ETW'(rem_reg);
                        wh_reg    <= padd(wh_reg, rem_reg);
                        wc_reg    <= wc_reg - rem_reg;
                        rem_reg   <= '0;
                        state_reg <= ret_reg;
                    end
                    else
                        state_reg <= S_EMIT_OUT;
                end

                S_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_byte_reg   <= pend_q;
                        byte_valid_reg <= 1'b1;
                        overflow_reg   <= 1'b0;
                        last_reg       <= ((ecnt_reg + ETW'(1)) == etot_reg);
                        ecnt_reg       <= ecnt_reg + ETW'(1);
                        wh_reg         <= padd(wh_reg, CW'(1));
                        wc_reg         <= wc_reg - CW'(1);
                        rem_reg        <= rem_reg - CW'(1);
                        state_reg      <= S_EMIT_RD;
                    end
                end

                S_FINISH:
                begin
                    if (dry_reg)
                    begin
                        if (rej_reg || (ecnt_reg > ETW'(gfbp_pkg::MAX_RESULTS)))
                        begin
                            rej_reg   <= 1'b1;
                            state_reg <= S_REPORT;
                        end
                        else
                        begin
                            etot_reg  <= ecnt_reg;
                            dry_reg   <= 1'b0;
                            state_reg <= S_START;
                        end
                    end
                    else
                    begin
                        h_reg  <= wh_reg;
                        c_reg  <= wc_reg;
                        sh_reg <= wsh_reg;
                        sc_reg <= wsc_reg;
                        hb_reg <= whb_reg;
                        if (etot_reg == ETW'(0))
                            state_reg <= S_REPORT;
                        else
                            state_reg <= S_IDLE;
                    end
                end

                S_REPORT:
                begin
                    // status-only result: nothing emitted, or rejected
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_byte_reg   <= 8'd0;
                        byte_valid_reg <= 1'b0;
                        overflow_reg   <= rej_reg;
                        last_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_reg <= CW'(PENDING_DEPTH))
        else $error("pending count beyond store depth");

    a_no_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg == SCW'(0) |-> c_reg == CW'(0))
        else $error("pending bytes left with no open slot");

    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && overflow_reg |-> last_reg && !byte_valid_reg)
        else $error("rejected request carried a byte");

    a_emit_real: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_OUT |-> !dry_reg)
        else $error("byte emitted during check pass");
`endif

endmodule
